// ===== sv/mcfir_pkg.sv =====
package mcfir_pkg;

  // default sizes, handed to the top level parameters
  localparam int DEF_MAX_TAPS     = 1024;
  localparam int DEF_MAX_CHANNELS = 8;
  localparam int DEF_SAMPLE_BITS  = 16;
  localparam int DEF_COEF_BITS    = 16;

  // fixed field widths
  localparam int CH_W       = 3;
  localparam int CIDX_W     = 10;
  localparam int TAP_CNT_W  = 11;
  localparam int GAIN_W     = 18;
  localparam int GAIN_FRAC  = 14;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 18;

  // register indexes and reset values
  localparam logic [CFG_ADDR_W-1:0] REG_TAP_COUNT   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_GAIN = 1'd1;
  localparam logic [TAP_CNT_W-1:0]  TAP_CNT_RESET   = 11'd1;
  localparam logic [GAIN_W-1:0]     GAIN_RESET      = 18'd16384;

  // item kinds carried on tuser
  typedef enum logic {
    FUNC_FILTER = 1'b0,
    FUNC_LOAD   = 1'b1
  } func_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_WRITE,
    S_MAC,
    S_DRAIN,
    S_ROUND,
    S_GAIN,
    S_FIN
  } state_t;

  // controls from the sequencer to the arithmetic unit
  typedef struct packed {
    logic mac_en;      // memory read data valid, multiply coef by sample
    logic acc_clr;     // clear accumulator
    logic v_from_x;    // load scale operand with the raw sample
    logic v_from_acc;  // load scale operand with the rounded sum
    logic gain_en;     // multiply scale operand by the gain
  } alu_ctrl_t;

endpackage

// ===== sv/mcfir_alu.sv =====
module mcfir_alu #(
  parameter int MAX_TAPS    = mcfir_pkg::DEF_MAX_TAPS,
  parameter int SAMPLE_BITS = mcfir_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_BITS   = mcfir_pkg::DEF_COEF_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mcfir_pkg::alu_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_BITS-1:0]        hist_rd,
  input  logic signed [COEF_BITS-1:0]          coef_rd,
  input  logic signed [SAMPLE_BITS-1:0]        x,
  input  logic        [mcfir_pkg::GAIN_W-1:0]  gain,
  output logic signed [SAMPLE_BITS-1:0]        res_sample,
  output logic                                 res_clip
);
  import mcfir_pkg::*;

  localparam int ACC_W = SAMPLE_BITS + COEF_BITS + $clog2(MAX_TAPS);
  localparam int V_W   = SAMPLE_BITS + $clog2(MAX_TAPS) + 2;
  localparam int B_W   = (COEF_BITS > GAIN_W + 1) ? COEF_BITS : GAIN_W + 1;
  localparam int P_W   = V_W + B_W;
  localparam int SC_W  = P_W + 1 - GAIN_FRAC;

  localparam logic signed [ACC_W:0]  ACC_HALF  = (ACC_W + 1)'(1) << (COEF_BITS - 2);
  localparam logic signed [P_W:0]    PROD_HALF = (P_W + 1)'(1) << (GAIN_FRAC - 1);
  localparam logic signed [SC_W-1:0] SAT_HI    = SC_W'((1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SC_W-1:0] SAT_LO    = SC_W'(-(1 <<< (SAMPLE_BITS - 1)));

  logic signed [V_W-1:0]   mul_a;
  logic signed [B_W-1:0]   mul_b;
  logic signed [P_W-1:0]   prod_r;
  logic                    mac_p_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [V_W-1:0]   v_r;
  logic signed [ACC_W:0]   acc_rnd;
  logic signed [P_W:0]     prod_rnd;
  logic signed [SC_W-1:0]  scaled;

  // operand select for the shared multiplier
  always_comb begin
    if (ctrl.gain_en) begin
      mul_a = v_r;
      mul_b = B_W'({1'b0, gain});
    end else begin
      mul_a = V_W'(hist_rd);
      mul_b = B_W'(coef_rd);
    end
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    if (ctrl.mac_en || ctrl.gain_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // product of a tap is waiting to be summed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_p_r <= 1'b0;
    end else begin
      mac_p_r <= ctrl.mac_en;
    end
  end

  // exact accumulation of tap products
  always_ff @(posedge clk) begin
    if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (mac_p_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // round the sum back to sample scale (floor after adding half)
  assign acc_rnd = {acc_r[ACC_W-1], acc_r} + ACC_HALF;

  always_ff @(posedge clk) begin
    if (ctrl.v_from_x) begin
      v_r <= V_W'(x);
    end else if (ctrl.v_from_acc) begin
      v_r <= acc_rnd[ACC_W:COEF_BITS-1];
    end
  end

  // gain rounding and saturation
  assign prod_rnd = {prod_r[P_W-1], prod_r} + PROD_HALF;
  assign scaled   = prod_rnd[P_W:GAIN_FRAC];

  always_comb begin
    res_clip   = 1'b0;
    res_sample = scaled[SAMPLE_BITS-1:0];
    if (scaled > SAT_HI) begin
      res_clip   = 1'b1;
      res_sample = SAT_HI[SAMPLE_BITS-1:0];
    end else if (scaled < SAT_LO) begin
      res_clip   = 1'b1;
      res_sample = SAT_LO[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== sv/multichannel_fir_filter.sv =====
// Multichannel FIR filter with one coefficient store shared by all channels.
// Input items arrive on in_t*; in_tuser selects the kind: filter (0) carries
// a sample for one channel, load (1) writes one coefficient and gives no item
// on the output. Each filter item for a channel below MAX_CHANNELS gives
// one item on out_t*: the filtered sample scaled by output_gain, rounded,
// saturated, with its channel and a clipped flag on out_tuser. Configuration
// is a plain write port (cfg_we, cfg_addr, cfg_wdata); the user must write it
// only while the block is idle; the block does not enforce this. A filter
// item on a primed channel is stored in its history, then summed by one
// multiply-accumulate per tap on the single shared multiplier, fed by one
// read port of the history memory. The first item of a channel sweeps its
// whole history with the sample, MAX_TAPS writes, and its result is that
// sample scaled by the gain. in_tready is high only while the sequencer is idle.
// The output register frees the input: a new item is taken while a result
// waits; if out_tready stays low, the next result waits in the sequencer.
// Reset (rst_n low, synchronous) marks every channel unprimed, clears the
// write positions and sets tap_count to 1 and output_gain to 1.0. The
// coefficient store is not cleared and must be loaded before use.
module multichannel_fir_filter #(
  parameter int MAX_TAPS     = mcfir_pkg::DEF_MAX_TAPS,
  parameter int MAX_CHANNELS = mcfir_pkg::DEF_MAX_CHANNELS,
  parameter int SAMPLE_BITS  = mcfir_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_BITS    = mcfir_pkg::DEF_COEF_BITS
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  // configuration write port
  input  logic                                              cfg_we,
  input  logic [mcfir_pkg::CFG_ADDR_W-1:0]                  cfg_addr,
  input  logic [mcfir_pkg::CFG_DATA_W-1:0]                  cfg_wdata,
  // input channel
  input  logic                                              in_tvalid,
  output logic                                              in_tready,
  // channel, sample_in, coef_index, coef_value (zero padded)
  input  logic [((13 + SAMPLE_BITS + COEF_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // func
  input  logic                                              in_tuser,
  // output channel
  output logic                                              out_tvalid,
  input  logic                                              out_tready,
  // sample_out, out_channel (zero padded)
  output logic [((SAMPLE_BITS + 3 + 7) / 8) * 8 - 1:0]      out_tdata,
  // clipped
  output logic                                              out_tuser
);
  import mcfir_pkg::*;

  localparam int IN_SMP_LO  = CH_W;
  localparam int IN_CIDX_LO = CH_W + SAMPLE_BITS;
  localparam int IN_CVAL_LO = CH_W + SAMPLE_BITS + CIDX_W;
  localparam int OUT_W      = ((SAMPLE_BITS + 3 + 7) / 8) * 8;
  localparam int IDX_W      = $clog2(MAX_TAPS);
  localparam int TAP_W      = $clog2(MAX_TAPS + 1);
  localparam int CHI_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int HA_W       = $clog2(MAX_CHANNELS * MAX_TAPS);

  // input fields
  logic [CH_W-1:0]               in_ch;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [CIDX_W-1:0]             in_cidx;
  logic signed [COEF_BITS-1:0]   in_cval;
  logic                          in_acc;
  logic                          ch_ok;
  logic [CHI_W-1:0]              chi_in;

  // configuration registers
  logic [TAP_CNT_W-1:0] cfg_tap_r;
  logic [GAIN_W-1:0]    cfg_gain_r;

  // sequencer state and item registers
  state_t                        state_r, state_nxt;
  logic [CH_W-1:0]               ch_r, ch_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic [TAP_W-1:0]              len_r, len_nxt;
  logic [HA_W-1:0]               base_r, base_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic [TAP_W-1:0]              k_r, k_nxt;
  logic                          drain_r, drain_nxt;
  logic                          rd_vld_r;

  // per channel state
  logic [IDX_W-1:0] wp_r [MAX_CHANNELS];
  logic             primed_r [MAX_CHANNELS];
  logic [CHI_W-1:0] chi_r;

  // memories
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_CHANNELS * MAX_TAPS];
  logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_rd_r;
  logic signed [COEF_BITS-1:0]   coef_rd_r;
  logic [HA_W-1:0]               hist_addr;

  // control
  logic             hist_we;
  logic             rd_en;
  logic             wp_we;
  logic [IDX_W-1:0] wp_val;
  logic             prime_set;
  logic             out_load;
  alu_ctrl_t        alu_ctrl;
  logic [TAP_W-1:0] len_in;
  logic [IDX_W-1:0] wp_cur;
  logic [IDX_W-1:0] p_in;

  // arithmetic results
  logic signed [SAMPLE_BITS-1:0] res_sample;
  logic                          res_clip;

  // output register
  logic                          out_tvalid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic [CH_W-1:0]               out_ch_r;
  logic                          out_clip_r;

  // unpack the input item
  assign in_ch     = in_tdata[CH_W-1:0];
  assign in_sample = in_tdata[IN_SMP_LO +: SAMPLE_BITS];
  assign in_cidx   = in_tdata[IN_CIDX_LO +: CIDX_W];
  assign in_cval   = in_tdata[IN_CVAL_LO +: COEF_BITS];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign ch_ok     = (32'(in_ch) < MAX_CHANNELS);
  assign chi_in    = CHI_W'(in_ch);
  assign chi_r     = CHI_W'(ch_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_tap_r  <= TAP_CNT_RESET;
      cfg_gain_r <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TAP_COUNT:   cfg_tap_r  <= cfg_wdata[TAP_CNT_W-1:0];
        REG_OUTPUT_GAIN: cfg_gain_r <= cfg_wdata[GAIN_W-1:0];
      endcase
    end
  end

  // tap count clamped to 1..MAX_TAPS, start position wrapped into range
  always_comb begin
    if (cfg_tap_r == '0) begin
      len_in = TAP_W'(1);
    end else if (32'(cfg_tap_r) > MAX_TAPS) begin
      len_in = TAP_W'(MAX_TAPS);
    end else begin
      len_in = TAP_W'(cfg_tap_r);
    end
    wp_cur = wp_r[chi_in];
    p_in   = (32'(wp_cur) >= 32'(len_in)) ? '0 : wp_cur;
  end

  assign hist_addr = base_r + HA_W'(idx_r);

  // sequencer: next state and controls
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    x_nxt     = x_r;
    len_nxt   = len_r;
    base_nxt  = base_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    drain_nxt = drain_r;
    hist_we   = 1'b0;
    rd_en     = 1'b0;
    wp_we     = 1'b0;
    wp_val    = '0;
    prime_set = 1'b0;
    out_load  = 1'b0;
    alu_ctrl  = '0;
    alu_ctrl.mac_en = rd_vld_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (func_t'(in_tuser) == FUNC_FILTER) && ch_ok) begin
          ch_nxt   = in_ch;
          x_nxt    = in_sample;
          len_nxt  = len_in;
          base_nxt = HA_W'(int'(chi_in) * MAX_TAPS);
          k_nxt    = '0;
          if (primed_r[chi_in]) begin
            idx_nxt   = p_in;
            state_nxt = S_WRITE;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_FILL;
          end
        end
      end
      S_FILL: begin
        // sweep the whole history of a fresh channel with its first sample
        hist_we           = 1'b1;
        alu_ctrl.v_from_x = 1'b1;
        idx_nxt           = idx_r + IDX_W'(1);
        if (idx_r == IDX_W'(MAX_TAPS - 1)) begin
          wp_we     = 1'b1;
          wp_val    = (len_r > TAP_W'(1)) ? IDX_W'(1) : '0;
          prime_set = 1'b1;
          state_nxt = S_GAIN;
        end
      end
      S_WRITE: begin
        // store the new sample, advance the write position
        hist_we          = 1'b1;
        alu_ctrl.acc_clr = 1'b1;
        wp_we            = 1'b1;
        wp_val = (TAP_W'(idx_r) + TAP_W'(1) == len_r) ? '0 : idx_r + IDX_W'(1);
        state_nxt        = S_MAC;
      end
      S_MAC: begin
        // one tap per cycle, history walked backward with wrap
        rd_en   = 1'b1;
        k_nxt   = k_r + TAP_W'(1);
        idx_nxt = (idx_r == '0) ? IDX_W'(len_r - TAP_W'(1)) : idx_r - IDX_W'(1);
        if (k_r == len_r - TAP_W'(1)) begin
          drain_nxt = 1'b0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // let the read and multiply stages empty into the accumulator
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        alu_ctrl.v_from_acc = 1'b1;
        state_nxt           = S_GAIN;
      end
      S_GAIN: begin
        alu_ctrl.gain_en = 1'b1;
        state_nxt        = S_FIN;
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_vld_r <= 1'b0;
      drain_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      drain_r  <= drain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r   <= ch_nxt;
    x_r    <= x_nxt;
    len_r  <= len_nxt;
    base_r <= base_nxt;
    idx_r  <= idx_nxt;
    k_r    <= k_nxt;
  end

  // write positions and primed flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        wp_r[i]     <= '0;
        primed_r[i] <= 1'b0;
      end
    end else begin
      if (wp_we) begin
        wp_r[chi_r] <= wp_val;
      end
      if (prime_set) begin
        primed_r[chi_r] <= 1'b1;
      end
    end
  end

  // sample history memory
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_addr] <= x_r;
    end
    if (rd_en) begin
      hist_rd_r <= hist_mem[hist_addr];
    end
  end

  // coefficient memory, written by load items
  always_ff @(posedge clk) begin
    if (in_acc && (func_t'(in_tuser) == FUNC_LOAD) && (32'(in_cidx) < MAX_TAPS)) begin
      coef_mem[IDX_W'(in_cidx)] <= in_cval;
    end
    if (rd_en) begin
      coef_rd_r <= coef_mem[k_r[IDX_W-1:0]];
    end
  end

  // shared multiply, accumulate, round and saturate
  mcfir_alu #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_alu (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (alu_ctrl),
    .hist_rd    (hist_rd_r),
    .coef_rd    (coef_rd_r),
    .x          (x_r),
    .gain       (cfg_gain_r),
    .res_sample (res_sample),
    .res_clip   (res_clip)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= res_sample;
      out_ch_r     <= ch_r;
      out_clip_r   <= res_clip;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'({out_ch_r, out_sample_r});
  assign out_tuser  = out_clip_r;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import mcfir_pkg::*;

  localparam int NTAPS  = DEF_MAX_TAPS;
  localparam int NCHAN  = DEF_MAX_CHANNELS;
  localparam int SMP_W  = DEF_SAMPLE_BITS;
  localparam int COEF_W = DEF_COEF_BITS;

  // in_tdata layout from the lowest bit: channel, sample, coef index, coef value
  localparam int SMP_LO  = CH_W;
  localparam int CIDX_LO = SMP_LO + SMP_W;
  localparam int CVAL_LO = CIDX_LO + CIDX_W;
  localparam int IN_W    = ((CH_W + SMP_W + CIDX_W + COEF_W + 7) / 8) * 8;
  localparam int OUT_W   = ((SMP_W + CH_W + 7) / 8) * 8;

  localparam longint SAT_HI = (longint'(1) << (SMP_W - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  localparam int RAND_ITEMS    = 560;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 20000;
  localparam int LONG_HOLD     = 2500;

  typedef struct {
    logic signed [SMP_W-1:0] value;
    logic [CH_W-1:0]         ch;
    logic                    clip;
  } fir_out_t;

  // filter state mirror and queue of filtered samples still to come out
  class fir_expect;
    logic signed [SMP_W-1:0]  history [NCHAN][NTAPS];
    logic signed [COEF_W-1:0] coefs [NTAPS];
    bit                       coef_written [NTAPS];
    int unsigned              wr_pos [NCHAN];
    bit                       primed [NCHAN];
    logic [TAP_CNT_W-1:0]     taps;
    logic [GAIN_W-1:0]        gain;
    fir_out_t                 pending_q [$];
    int errors, n_filtered, n_loaded, n_clipped, n_checked;

    function new();
      taps = TAP_CNT_RESET;
      gain = GAIN_RESET;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, int unsigned val);
      if (idx == REG_TAP_COUNT) taps = val[TAP_CNT_W-1:0];
      else if (idx == REG_OUTPUT_GAIN) gain = val[GAIN_W-1:0];
    endfunction

    // tap count clamped to 1..NTAPS
    function int unsigned used_taps();
      int unsigned len;
      len = taps;
      if (len < 1) len = 1;
      if (len > NTAPS) len = NTAPS;
      return len;
    endfunction

    // round half up, then floor divide by 2^n
    function longint rnd_shr(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    // gain scaling, second rounding and saturation
    function fir_out_t apply_gain(longint x, logic [CH_W-1:0] ch);
      fir_out_t r;
      longint s;
      s = rnd_shr(x * longint'(gain), GAIN_FRAC);
      r.clip = 1'b0;
      if (s > SAT_HI) begin
        s = SAT_HI;
        r.clip = 1'b1;
      end
      if (s < SAT_LO) begin
        s = SAT_LO;
        r.clip = 1'b1;
      end
      r.value = s[SMP_W-1:0];
      r.ch = ch;
      return r;
    endfunction

    function void take_item(func_t kind, logic [CH_W-1:0] ch, logic signed [SMP_W-1:0] smp,
                            logic [CIDX_W-1:0] cidx, logic signed [COEF_W-1:0] cval);
      int unsigned len, p, idx;
      longint acc;
      if (kind == FUNC_LOAD) begin
        if (cidx < NTAPS) begin
          coefs[cidx] = cval;
          coef_written[cidx] = 1'b1;
        end
        n_loaded++;
        return;
      end
      if (ch >= NCHAN) return;
      n_filtered++;
      len = used_taps();
      // first sample of a channel floods its history
      if (!primed[ch]) begin
        for (int k = 0; k < NTAPS; k++) history[ch][k] = smp;
        primed[ch] = 1'b1;
        wr_pos[ch] = (len > 1) ? 1 : 0;
        pending_q.push_back(apply_gain(longint'(smp), ch));
        return;
      end
      // position wraps if the tap count was lowered
      p = wr_pos[ch];
      if (p >= len) p = 0;
      history[ch][p] = smp;
      acc = 0;
      for (int unsigned k = 0; k < len; k++) begin
        idx = (p + len - k) % len;
        acc += longint'(coefs[k]) * longint'(history[ch][idx]);
      end
      wr_pos[ch] = (p + 1) % len;
      pending_q.push_back(apply_gain(rnd_shr(acc, COEF_W - 1), ch));
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void check_sample(logic [OUT_W-1:0] d, logic clip);
      fir_out_t e;
      logic signed [SMP_W-1:0] v;
      logic [CH_W-1:0] c;
      v = d[SMP_W-1:0];
      c = d[SMP_W +: CH_W];
      n_checked++;
      if (clip) n_clipped++;
      if (pending_q.size() == 0) begin
        note_error($sformatf("unexpected result sample %0d ch %0d clip %0d", v, c, clip));
        return;
      end
      e = pending_q.pop_front();
      if (v !== e.value || c !== e.ch || clip !== e.clip)
        note_error($sformatf("expected sample %0d ch %0d clip %0d, got sample %0d ch %0d clip %0d",
                             e.value, e.ch, e.clip, v, c, clip));
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tuser;

  fir_expect sb = new();
  bit        hold_off_req = 1'b0;
  int        burst_left = 0;
  int        quiet_cycles = 0;

  multichannel_fir_filter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // handshake monitor, result check and watchdog
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_sample(out_tdata, out_tuser);
    if (in_tvalid && in_tready)
      sb.take_item(func_t'(in_tuser), in_tdata[CH_W-1:0], in_tdata[SMP_LO +: SMP_W],
                   in_tdata[CIDX_LO +: CIDX_W], in_tdata[CVAL_LO +: COEF_W]);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] watchdog: no item moved for %0d cycles", $realtime, QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver back-pressure: alternating ready and stall runs, one long hold on request
  always begin : rx_pattern
    int unsigned run;
    bit level;
    @(negedge clk);
    if (hold_off_req) begin
      level = 1'b0;
      run = LONG_HOLD;
      hold_off_req = 1'b0;
    end else begin
      level = !out_tready;
      if (level) run = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      else run = $urandom_range(1, 6);
    end
    out_tready <= level;
    repeat (run - 1) @(negedge clk);
  end

  // offer one item, with bursts separated by random gaps
  task automatic push_item(input func_t kind, input logic [CH_W-1:0] ch,
                           input logic [SMP_W-1:0] smp, input logic [CIDX_W-1:0] cidx,
                           input logic [COEF_W-1:0] cval);
    logic [IN_W-1:0] d;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    d = '0;
    d[CH_W-1:0] = ch;
    d[SMP_LO +: SMP_W] = smp;
    d[CIDX_LO +: CIDX_W] = cidx;
    d[CVAL_LO +: COEF_W] = cval;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp);
    push_item(FUNC_FILTER, ch, smp, CIDX_W'($urandom), COEF_W'($urandom));
  endtask

  task automatic send_coef(input logic [CIDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    push_item(FUNC_LOAD, CH_W'($urandom), SMP_W'($urandom), idx, val);
  endtask

  // stop offering and wait until every filtered sample has come out
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(SMP_W-1){1'b1}}};
      1:       return {1'b1, {(SMP_W-1){1'b0}}};
      2:       return '0;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef(int unsigned shift);
    logic signed [COEF_W-1:0] c;
    c = COEF_W'($urandom);
    return c >>> shift;
  endfunction

  initial begin
    int phase, n_items, rand_items, taps;
    int unsigned len, shift, gain_v;
    bit reload;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset values, field extremes, saturation, gain extremes
    send_sample(3'd0, 16'sh7FFF);
    send_sample(3'd1, 16'sh8000);
    send_coef(10'd0, 16'sh8000);
    send_coef(10'd1023, 16'sh7FFF);
    send_sample(3'd0, 16'sh8000);
    send_sample(3'd1, 16'sh7FFF);
    settle();
    write_reg(REG_OUTPUT_GAIN, (1 << GAIN_W) - 1);
    send_sample(3'd2, 16'sd1);
    send_sample(3'd3, 16'sh8000);
    send_sample(3'd0, 16'sd0);
    settle();
    write_reg(REG_OUTPUT_GAIN, 0);
    send_sample(3'd4, 16'sh7FFF);
    // tap count zero behaves as one tap
    settle();
    write_reg(REG_OUTPUT_GAIN, GAIN_RESET);
    write_reg(REG_TAP_COUNT, 0);
    send_sample(3'd0, rand_sample());
    send_coef(10'd1, 16'sh4000);
    send_coef(10'd2, 16'shE000);
    // advance the write position, then lower the tap count below it
    settle();
    write_reg(REG_TAP_COUNT, 3);
    send_sample(3'd0, rand_sample());
    send_sample(3'd0, rand_sample());
    settle();
    write_reg(REG_TAP_COUNT, 2);
    send_sample(3'd0, rand_sample());
    send_sample(3'd5, rand_sample());
    send_sample(3'd6, 16'sh7FFF);
    send_sample(3'd7, 16'shFFFF);
    send_sample(3'd5, rand_sample());

    // random phases, each with its own tap count, gain and coefficient scale
    phase = 0;
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      if (phase == 0) taps = 0;
      else if (phase == 1) taps = NTAPS;
      else if (phase == 2) taps = (1 << TAP_CNT_W) - 1;
      else if (phase == 3) taps = 1;
      else if (phase == 5) taps = 4;
      else if ($urandom_range(0, 9) < 6) taps = $urandom_range(1, 16);
      else if ($urandom_range(0, 3) != 0) taps = $urandom_range(17, 96);
      else taps = $urandom_range(97, 300);

      if (phase == 2) gain_v = (1 << GAIN_W) - 1;
      else if (phase == 4) gain_v = 0;
      else if ($urandom_range(0, 3) == 0) gain_v = GAIN_RESET;
      else if ($urandom_range(0, 2) == 0) gain_v = $urandom_range(0, (1 << GAIN_W) - 1);
      else gain_v = $urandom_range(8192, 24576);

      settle();
      write_reg(REG_TAP_COUNT, taps);
      write_reg(REG_OUTPUT_GAIN, gain_v);
      len = sb.used_taps();

      // coefficient scale: full range now and then, else sized so the sum rarely clips
      if ($urandom_range(0, 3) == 0) shift = 0;
      else shift = $clog2(len) + $urandom_range(0, 1);
      if (shift > COEF_W - 1) shift = COEF_W - 1;

      // every tap in use must hold a loaded coefficient
      reload = $urandom_range(0, 1);
      for (int unsigned k = 0; k < len; k++)
        if (reload || !sb.coef_written[k]) send_coef(k, rand_coef(shift));

      // one phase starves the output so the block backs up into its input
      if (phase == 5) hold_off_req = 1'b1;

      n_items = (len > 300) ? 6 : $urandom_range(25, 45);
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 6) == 0) begin
          if ($urandom_range(0, 1) == 0) send_coef($urandom_range(0, len - 1), rand_coef(shift));
          else send_coef($urandom_range(0, NTAPS - 1), rand_coef(shift));
        end else begin
          send_sample($urandom_range(0, NCHAN - 1), rand_sample());
        end
        rand_items++;
      end
      phase++;
    end

    settle();
    $display("run: %0d samples filtered, %0d coefficients loaded, %0d results checked, %0d clipped",
             sb.n_filtered, sb.n_loaded, sb.n_checked, sb.n_clipped);
    $display("run: %0d random phases, tap counts 0 to %0d, gain 0 to full scale, %0d mismatches",
             phase, (1 << TAP_CNT_W) - 1, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
